// ----- hw/rtl/center_crop_nearest_resize_macros.svh -----
// Assertion macros used by the center crop resize checker.
`ifndef CENTER_CROP_NEAREST_RESIZE_MACROS_SVH
`define CENTER_CROP_NEAREST_RESIZE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define CCNR_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("center_crop_nearest_resize: assertion failed");

// Clocked assertion that is also checked during reset.
`define CCNR_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("center_crop_nearest_resize: assertion failed");

`endif

// ----- hw/rtl/ccnr_pkg.sv -----
// Shared constants, types and register codes of the center crop resizer.
package ccnr_pkg;

   localparam int OUT_SIDE        = 96;
   localparam int MAX_SOURCE_SIDE = 2048;

   localparam int PIX_W   = 8;
   localparam int RGB_W   = 3 * PIX_W;
   localparam int SIDE_W  = 12;
   localparam int POS_W   = 11;
   localparam int WANT_W  = 12;
   localparam int OUT_W   = $clog2(OUT_SIDE);
   localparam int REM_W   = $clog2(OUT_SIDE);
   localparam int STEP_W  = 5;

   // crop / OUT_SIDE as (crop * DIV_MUL) >> DIV_SHIFT, exact for crop <= MAX_SOURCE_SIDE
   localparam int DIV_MUL   = 683;
   localparam int DIV_SHIFT = 16;
   localparam int PROD_W    = 22;

   localparam logic [SIDE_W-1:0] RESET_SOURCE_WIDTH  = 12'd160;
   localparam logic [SIDE_W-1:0] RESET_SOURCE_HEIGHT = 12'd120;

   localparam int RESET_CROP   = (160 < 120) ? 160 : 120;
   localparam int RESET_CROP_X = (160 - RESET_CROP) / 2;
   localparam int RESET_CROP_Y = (120 - RESET_CROP) / 2;

   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 1'b0,
      CSR_SOURCE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SIDE_W-1:0] eff_width;
      logic [SIDE_W-1:0] eff_height;
      logic [POS_W-1:0]  crop_x;
      logic [POS_W-1:0]  crop_y;
      logic [STEP_W-1:0] step_q;
      logic [REM_W-1:0]  step_r;
   } geom_type;

   typedef struct packed {
      logic hit;
      logic last;
   } sel_type;

endpackage

// ----- hw/rtl/center_crop_nearest_resize.sv -----
// Center crop nearest-neighbor downscaler, top level.
//
// req_ carries source RGB pixels in raster order, one beat per pixel; req_tuser
// marks the first pixel of a frame and restarts all counters. rsp_ carries the
// selected pixels of the OUT_SIDE x OUT_SIDE output image, with rsp_tlast on
// its final pixel. Zero or one rsp beat follows each req beat.
// csr_ writes source_width (index 0) or source_height (index 1); csr_ready is
// always high and a write takes effect on the next beat.
// Throughput: one pixel per clock while rsp_ is not stalled. A pixel is held in
// the input register, checked against the wanted position and, if kept, lands in
// the output register, which drives rsp_tvalid.
// If rsp_ stalls while a kept pixel waits, the input register holds at most
// one more pixel; pixels that are dropped keep flowing only while no kept
// pixel is blocked behind the output register.
// Reset (synchronous) empties both registers, restores 160 x 120 geometry and
// starts a new frame.
module center_crop_nearest_resize
   import ccnr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [RGB_W-1:0]       req_tdata,   // red_in, green_in, blue_in
   input  logic                   req_tuser,   // frame_start
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RGB_W-1:0]       rsp_tdata,   // red_out, green_out, blue_out
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIDE_W-1:0]      csr_data
);

   geom_type         geom;
   sel_type          sel;
   logic             in_valid_ff;
   logic [RGB_W-1:0] in_data_ff;
   logic             in_fs_ff;
   logic             out_valid_ff;
   logic [RGB_W-1:0] out_data_ff;
   logic             out_last_ff;
   logic             step;

   ccnr_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   ccnr_select u_select (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .step        (step),
      .frame_start (in_fs_ff),
      .sel         (sel)
   );

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready || !sel.hit);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_tdata;
         in_fs_ff   <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && sel.hit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && sel.hit) begin
         out_data_ff <= in_data_ff;
         out_last_ff <= sel.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hw/rtl/ccnr_geom.sv -----
// Geometry registers: source size, crop offsets and resampling step.
module ccnr_geom
   import ccnr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIDE_W-1:0]      csr_data,
   output geom_type               geom
);

   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   geom_type          geom_ff, geom_in, geom_rst;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v < SIDE_W'(OUT_SIDE)) r = SIDE_W'(OUT_SIDE);
      else if (v > SIDE_W'(MAX_SOURCE_SIDE)) r = SIDE_W'(MAX_SOURCE_SIDE);
      else r = v;
      return r;
   endfunction

   function automatic geom_type geom_from(input logic [SIDE_W-1:0] w,
                                          input logic [SIDE_W-1:0] h);
      geom_type          g;
      logic [SIDE_W-1:0] crop;
      logic [SIDE_W-1:0] dx;
      logic [SIDE_W-1:0] dy;
      logic [PROD_W-1:0] prod;
      logic [SIDE_W-1:0] rem;
      g.eff_width  = clamp_side(w);
      g.eff_height = clamp_side(h);
      crop = (g.eff_width < g.eff_height) ? g.eff_width : g.eff_height;
      dx = g.eff_width - crop;
      dy = g.eff_height - crop;
      g.crop_x = dx[SIDE_W-1:1];
      g.crop_y = dy[SIDE_W-1:1];
      prod = PROD_W'(crop) * PROD_W'(DIV_MUL);
      g.step_q = prod[DIV_SHIFT +: STEP_W];
      rem = crop - SIDE_W'(g.step_q) * SIDE_W'(OUT_SIDE);
      g.step_r = rem[REM_W-1:0];
      return g;
   endfunction

   assign csr_ready = 1'b1;
   assign geom_rst  = geom_from(RESET_SOURCE_WIDTH, RESET_SOURCE_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      unique case (csr_index_type'(csr_index))
         CSR_SOURCE_WIDTH:  width_in  = csr_data;
         CSR_SOURCE_HEIGHT: height_in = csr_data;
         default: ;
      endcase
      geom_in = geom_from(width_in, height_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SOURCE_WIDTH;
         height_ff <= RESET_SOURCE_HEIGHT;
         geom_ff   <= geom_rst;
      end else if (csr_valid) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         geom_ff   <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

// ----- hw/rtl/ccnr_select.sv -----
// Source and output position counters; flags the pixels to keep.
module ccnr_select
   import ccnr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     step,
   input  logic     frame_start,
   output sel_type  sel
);

   localparam logic [OUT_W-1:0] OUT_LAST = OUT_W'(OUT_SIDE - 1);

   logic [POS_W-1:0]  src_col_ff, src_col_in, cur_col;
   logic [POS_W-1:0]  src_row_ff, src_row_in, cur_row;
   logic [OUT_W-1:0]  out_col_ff, out_col_in, cur_oc;
   logic [OUT_W-1:0]  out_row_ff, out_row_in, cur_or;
   logic [WANT_W-1:0] want_col_ff, want_col_in, cur_wc;
   logic [WANT_W-1:0] want_row_ff, want_row_in, cur_wr;
   logic [REM_W-1:0]  col_rem_ff, col_rem_in, cur_cr;
   logic [REM_W-1:0]  row_rem_ff, row_rem_in, cur_rr;
   logic              done_ff, done_in, cur_done;

   logic              hit;
   logic [REM_W:0]    col_rem_sum, row_rem_sum;
   logic              col_carry, row_carry;
   logic [REM_W:0]    col_rem_adj, row_rem_adj;
   logic [SIDE_W-1:0] col_inc, row_inc;

   always_comb begin
      if (frame_start) begin
         cur_col  = '0;
         cur_row  = '0;
         cur_oc   = '0;
         cur_or   = '0;
         cur_wc   = WANT_W'(geom.crop_x);
         cur_wr   = WANT_W'(geom.crop_y);
         cur_cr   = '0;
         cur_rr   = '0;
         cur_done = 1'b0;
      end else begin
         cur_col  = src_col_ff;
         cur_row  = src_row_ff;
         cur_oc   = out_col_ff;
         cur_or   = out_row_ff;
         cur_wc   = want_col_ff;
         cur_wr   = want_row_ff;
         cur_cr   = col_rem_ff;
         cur_rr   = row_rem_ff;
         cur_done = done_ff;
      end

      hit = !cur_done && (WANT_W'(cur_row) == cur_wr) && (WANT_W'(cur_col) == cur_wc);

      col_rem_sum = {1'b0, cur_cr} + {1'b0, geom.step_r};
      col_carry   = col_rem_sum >= (REM_W+1)'(OUT_SIDE);
      col_rem_adj = col_rem_sum - (REM_W+1)'(OUT_SIDE);
      row_rem_sum = {1'b0, cur_rr} + {1'b0, geom.step_r};
      row_carry   = row_rem_sum >= (REM_W+1)'(OUT_SIDE);
      row_rem_adj = row_rem_sum - (REM_W+1)'(OUT_SIDE);

      src_col_in  = cur_col;
      src_row_in  = cur_row;
      out_col_in  = cur_oc;
      out_row_in  = cur_or;
      want_col_in = cur_wc;
      want_row_in = cur_wr;
      col_rem_in  = cur_cr;
      row_rem_in  = cur_rr;
      done_in     = cur_done;

      if (hit) begin
         if (cur_oc == OUT_LAST) begin
            out_col_in  = '0;
            want_col_in = WANT_W'(geom.crop_x);
            col_rem_in  = '0;
            want_row_in = cur_wr + WANT_W'(geom.step_q) + WANT_W'(row_carry);
            row_rem_in  = row_carry ? row_rem_adj[REM_W-1:0] : row_rem_sum[REM_W-1:0];
            if (cur_or == OUT_LAST) begin
               out_row_in = '0;
               done_in    = 1'b1;
            end else begin
               out_row_in = cur_or + 1'b1;
            end
         end else begin
            out_col_in  = cur_oc + 1'b1;
            want_col_in = cur_wc + WANT_W'(geom.step_q) + WANT_W'(col_carry);
            col_rem_in  = col_carry ? col_rem_adj[REM_W-1:0] : col_rem_sum[REM_W-1:0];
         end
      end

      col_inc = SIDE_W'(cur_col) + 1'b1;
      row_inc = SIDE_W'(cur_row) + 1'b1;
      if (col_inc >= geom.eff_width) begin
         src_col_in = '0;
         if (row_inc >= geom.eff_height) begin
            src_row_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            want_col_in = WANT_W'(geom.crop_x);
            want_row_in = WANT_W'(geom.crop_y);
            col_rem_in  = '0;
            row_rem_in  = '0;
            done_in     = 1'b0;
         end else begin
            src_row_in = row_inc[POS_W-1:0];
         end
      end else begin
         src_col_in = col_inc[POS_W-1:0];
      end

      sel.hit  = hit;
      sel.last = (cur_oc == OUT_LAST) && (cur_or == OUT_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         want_col_ff <= WANT_W'(RESET_CROP_X);
         want_row_ff <= WANT_W'(RESET_CROP_Y);
         col_rem_ff  <= '0;
         row_rem_ff  <= '0;
         done_ff     <= 1'b0;
      end else if (step) begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         want_col_ff <= want_col_in;
         want_row_ff <= want_row_in;
         col_rem_ff  <= col_rem_in;
         row_rem_ff  <= row_rem_in;
         done_ff     <= done_in;
      end
   end

endmodule

// ----- hw/rtl/ccnr_checker.sv -----
// Port-level checker for the center crop resizer, bound to the top level.
`include "center_crop_nearest_resize_macros.svh"

module ccnr_checker
   import ccnr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RGB_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   logic [RGB_W:0] rsp_beat;

   assign rsp_beat = {rsp_tlast, rsp_tdata};

   // reset empties the output register
   `CCNR_ASSERT(a_reset_clears, clock, reset |=> !rsp_tvalid)

   // a stalled beat holds its payload
   `CCNR_ASSERT_RST(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_beat))

   // with no result waiting the input side never stalls
   `CCNR_ASSERT_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // the beat after a frame's accepted last pixel is not marked last as well
   `CCNR_ASSERT_RST(a_no_double_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> !(rsp_tvalid && rsp_tlast))

endmodule

bind center_crop_nearest_resize ccnr_checker u_checker (.*);

// ----- sim/testbench.sv -----
// Stream-level test of the center crop resizer: pixels checked against an in-bench selector.
module testbench
   import ccnr_pkg::*;
();

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last;
   } out_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RGB_W-1:0]       req_tdata = '0;   // red_in, green_in, blue_in
   logic                   req_tuser = 1'b0; // frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RGB_W-1:0]       rsp_tdata;        // red_out, green_out, blue_out
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SOURCE_WIDTH;
   logic [SIDE_W-1:0]      csr_data = '0;

   center_crop_nearest_resize DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // selector state
   logic [SIDE_W-1:0] width_reg;
   logic [SIDE_W-1:0] height_reg;
   logic [POS_W-1:0]  src_col;
   logic [POS_W-1:0]  src_row;
   logic [OUT_W-1:0]  out_col;
   logic [OUT_W-1:0]  out_row;
   logic [WANT_W-1:0] want_col;
   logic [WANT_W-1:0] want_row;
   logic [REM_W-1:0]  col_rem;
   logic [REM_W-1:0]  row_rem;
   logic              frame_done;

   out_pixel_type kept_pixels[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;

   function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] v);
      if (v < OUT_SIDE) return OUT_SIDE;
      if (v > MAX_SOURCE_SIDE) return MAX_SOURCE_SIDE;
      return v;
   endfunction

   function automatic int unsigned crop_side();
      int unsigned w;
      int unsigned h;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      return (w < h) ? w : h;
   endfunction

   task automatic restart_counters();
      int unsigned c;
      c = crop_side();
      src_col = '0;
      src_row = '0;
      out_col = '0;
      out_row = '0;
      want_col = WANT_W'((clamp_side(width_reg) - c) / 2);
      want_row = WANT_W'((clamp_side(height_reg) - c) / 2);
      col_rem = '0;
      row_rem = '0;
      frame_done = 1'b0;
   endtask

   task automatic step_wanted(inout logic [WANT_W-1:0] pos, inout logic [REM_W-1:0] rem);
      int unsigned c;
      int unsigned p;
      int unsigned r;
      c = crop_side();
      p = pos + c / OUT_SIDE;
      r = rem + c % OUT_SIDE;
      if (r >= OUT_SIDE) begin
         r = r - OUT_SIDE;
         p = p + 1;
      end
      pos = WANT_W'(p);
      rem = REM_W'(r);
   endtask

   task automatic select_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
      int unsigned w;
      int unsigned c;
      int unsigned col_next;
      int unsigned row_next;
      out_pixel_type kept;
      w = clamp_side(width_reg);
      if (fs) restart_counters();
      if (!frame_done && src_row == want_row && src_col == want_col) begin
         kept.red = r;
         kept.green = g;
         kept.blue = b;
         kept.last = (out_col == OUT_SIDE - 1) && (out_row == OUT_SIDE - 1);
         kept_pixels.push_back(kept);
         out_col = out_col + 1'b1;
         step_wanted(want_col, col_rem);
         if (out_col >= OUT_SIDE) begin
            c = crop_side();
            out_col = '0;
            want_col = WANT_W'((w - c) / 2);
            col_rem = '0;
            out_row = out_row + 1'b1;
            step_wanted(want_row, row_rem);
            if (out_row >= OUT_SIDE) begin
               out_row = '0;
               frame_done = 1'b1;
            end
         end
      end
      col_next = src_col + 1;
      if (col_next >= w) begin
         src_col = '0;
         row_next = src_row + 1;
         if (row_next >= clamp_side(height_reg)) restart_counters();
         else src_row = POS_W'(row_next);
      end else begin
         src_col = POS_W'(col_next);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_result();
      out_pixel_type want;
      if (kept_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel %h last %b", rsp_tdata, rsp_tlast));
      end else begin
         want = kept_pixels.pop_front();
         if (rsp_tdata[PIX_W-1:0] !== want.red)
            report_mismatch($sformatf("red %h, want %h", rsp_tdata[PIX_W-1:0], want.red));
         if (rsp_tdata[2*PIX_W-1:PIX_W] !== want.green)
            report_mismatch($sformatf("green %h, want %h", rsp_tdata[2*PIX_W-1:PIX_W],
                                      want.green));
         if (rsp_tdata[3*PIX_W-1:2*PIX_W] !== want.blue)
            report_mismatch($sformatf("blue %h, want %h", rsp_tdata[3*PIX_W-1:2*PIX_W],
                                      want.blue));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", rsp_tlast, want.last));
      end
   endtask

   // result side: check, then decide tready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      req_tuser <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      select_pixel(r, g, b, fs);
   endtask

   task automatic send_run(input int count, input logic first_flag, input int flag_pct);
      logic fs;
      for (int i = 0; i < count; i++) begin
         fs = (i == 0) ? first_flag : ($urandom_range(99) < flag_pct);
         send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                    PIX_W'($urandom_range(255)), fs);
      end
   endtask

   // wait until all kept pixels are out, plus the pipeline depth for dropped ones
   task automatic drain();
      req_tvalid <= 1'b0;
      while (kept_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [SIDE_W-1:0] w, h);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      width_reg = w;
      csr_index <= CSR_SOURCE_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      height_reg = h;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] pattern_byte(input int i);
      case (i % 6)
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'hAA;
         3: return 8'h55;
         4: return 8'h01;
         default: return 8'h80;
      endcase
   endfunction

   function automatic logic [SIDE_W-1:0] pick_side();
      int k;
      k = $urandom_range(99);
      if (k < 6) return SIDE_W'($urandom_range(OUT_SIDE - 1));
      if (k < 10) return SIDE_W'($urandom_range(4095, MAX_SOURCE_SIDE + 1));
      if (k < 20) return SIDE_W'($urandom_range(MAX_SOURCE_SIDE, 257));
      return SIDE_W'($urandom_range(256, OUT_SIDE));
   endfunction

   // 160 x 120 after reset: crop 120 starting at column 20
   task automatic test_reset_geometry();
      for (int i = 0; i < 24; i++)
         send_pixel(pattern_byte(i), pattern_byte(i + 1), pattern_byte(i + 2), i == 0);
   endtask

   // both registers below range clamp to 96 x 96; frame start mid-row resyncs
   task automatic test_frame_resync();
      set_geometry(12'd0, 12'd95);
      for (int i = 0; i < 16; i++)
         send_pixel(pattern_byte(i + 3), pattern_byte(i + 4), pattern_byte(i + 5),
                    i == 0 || i == 9);
   endtask

   task automatic test_register_extremes();
      set_geometry(12'd2048, 12'd2048);
      send_run(150, 1'b1, 0);
      set_geometry(12'd96, 12'd2048);
      send_run(150, 1'b1, 0);
      set_geometry(12'd4095, 12'd96);
      send_run(100, 1'b1, 0);
   endtask

   // source rows wrap at the width; the second run goes on without a frame start
   task automatic test_row_wrap();
      set_geometry(12'd100, 12'd96);
      send_run(150, 1'b1, 0);
      send_run(100, 1'b0, 0);
   endtask

   task automatic test_midframe_config();
      set_geometry(12'd200, 12'd150);
      send_run(150, 1'b1, 0);
      set_geometry(12'd120, 12'd100);
      send_run(100, 1'b0, 0);
      set_geometry(12'd97, 12'd300);
      send_run(50, 1'b0, 0);
   endtask

   // result side held off while every pixel is kept: input must back up
   task automatic test_pressure();
      set_geometry(12'd96, 12'd96);
      hold_request = 1'b1;
      send_run(200, 1'b1, 0);
   endtask

   task automatic test_random_traffic(input int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         drain();
         if ($urandom_range(99) < 70) set_geometry(pick_side(), pick_side());
         n = $urandom_range(160, 20);
         send_run(n, $urandom_range(99) < 75, 2);
         sent += n;
      end
   endtask

   task automatic finish_run();
      drain();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   endtask

   initial begin
      width_reg = RESET_SOURCE_WIDTH;
      height_reg = RESET_SOURCE_HEIGHT;
      restart_counters();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 45;
      test_reset_geometry();
      test_frame_resync();
      test_register_extremes();
      test_random_traffic(80);

      send_idle_pct = 45;
      recv_idle_pct = 21;
      test_row_wrap();
      test_midframe_config();
      test_random_traffic(80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_pressure();
      test_random_traffic(80);

      finish_run();
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ccnr_pkg.sv
hw/rtl/ccnr_geom.sv
hw/rtl/ccnr_select.sv
hw/rtl/center_crop_nearest_resize.sv
hw/rtl/ccnr_checker.sv
sim/testbench.sv
